// ===== rtl/sfla_pkg.sv =====
`timescale 1ns / 1ps

package sfla_pkg;

   localparam int SLOTS  = 1024;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   localparam int ID_W    = 10;
   localparam int FD_W    = 16;
   localparam int DATA_W  = 32;
   localparam int MIDX_W  = 15;
   localparam int MEM_W   = 16;
   localparam int LIVE_W  = 11;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   localparam logic [MEM_W-1:0] NONE_MEM = '1;

   typedef enum logic [1:0] {
      REQ_ALLOC  = 2'd0,
      REQ_FREE   = 2'd1,
      REQ_MODIFY = 2'd2,
      REQ_LOOKUP = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_FREE    = 2'd1,
      STATUS_NOT_IN_USE = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic              in_use;
      logic [CNT_W-1:0]  next;
      logic [FD_W-1:0]   fd;
      logic [DATA_W-1:0] data;
      logic [MEM_W-1:0]  mem;
   } row_type;

endpackage

// ===== rtl/sfla_ctrl.sv =====
`timescale 1ns / 1ps

module sfla_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output sfla_pkg::cmd_type cmd
);

   sfla_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfla_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.accept   = 1'b0;
      cmd.commit   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         sfla_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sfla_pkg::ST_EXEC;
            end
         end
         sfla_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sfla_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfla_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/sfla_dp.sv =====
`timescale 1ns / 1ps

module sfla_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sfla_pkg::cmd_type                   cmd,
   input  logic [sfla_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,
   output logic [sfla_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser
);

   sfla_pkg::row_type slot_ram [sfla_pkg::SLOTS];
   sfla_pkg::row_type rd_row_ff;
   sfla_pkg::row_type wr_row;
   logic              wr_en;

   logic [sfla_pkg::CNT_W-1:0] head_ff, head_in;
   logic [sfla_pkg::CNT_W-1:0] fresh_ff, fresh_in;
   logic [sfla_pkg::CNT_W-1:0] count_ff, count_in;

   sfla_pkg::req_kind_type          kind_ff;
   logic [sfla_pkg::ID_W-1:0]       slot_ff;
   logic [sfla_pkg::FD_W-1:0]       fd_ff;
   logic [sfla_pkg::DATA_W-1:0]     data_ff;
   logic [sfla_pkg::MEM_W-1:0]      newmem_ff;
   logic [sfla_pkg::SLOT_W-1:0]     addr_ff;

   logic [sfla_pkg::ID_W-1:0]       in_slot;
   logic [sfla_pkg::SLOT_W-1:0]     rd_addr;
   sfla_pkg::req_kind_type          in_kind;

   logic                            live;
   logic                            head_fresh;

   sfla_pkg::status_type            o_status;
   logic [sfla_pkg::ID_W-1:0]       o_slot;
   logic [sfla_pkg::FD_W-1:0]       o_fd;
   logic [sfla_pkg::DATA_W-1:0]     o_data;
   logic [sfla_pkg::MEM_W-1:0]      o_mem;
   logic                            o_rel;

   sfla_pkg::status_type            status_ff;
   logic [sfla_pkg::ID_W-1:0]       slot_out_ff;
   logic [sfla_pkg::FD_W-1:0]       fd_out_ff;
   logic [sfla_pkg::DATA_W-1:0]     data_out_ff;
   logic [sfla_pkg::MEM_W-1:0]      mem_out_ff;
   logic                            rel_ff;
   logic [sfla_pkg::LIVE_W-1:0]     live_ff;

   assign in_kind = sfla_pkg::req_kind_type'(req_tuser);
   assign in_slot = req_tdata[9:0];
   assign rd_addr = (in_kind == sfla_pkg::REQ_ALLOC) ? sfla_pkg::SLOT_W'(head_ff)
                                                     : sfla_pkg::SLOT_W'(in_slot);

   // Slots at or above the fill mark were never handed out, so their rows hold
   // nothing yet; they count as not in use and as linked in slot order.
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         slot_ram[addr_ff] <= wr_row;
      end
      if (cmd.accept) begin
         rd_row_ff <= slot_ram[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= in_kind;
         slot_ff   <= in_slot;
         fd_ff     <= req_tdata[25:10];
         data_ff   <= req_tdata[57:26];
         newmem_ff <= req_tdata[58] ? {1'b0, req_tdata[73:59]} : sfla_pkg::NONE_MEM;
         addr_ff   <= rd_addr;
      end
   end

   assign live = (32'(slot_ff) < 32'(sfla_pkg::SLOTS)) &&
                 (32'(slot_ff) < 32'(fresh_ff)) && rd_row_ff.in_use;
   assign head_fresh = (head_ff >= fresh_ff);

   always_comb begin
      wr_en    = 1'b0;
      wr_row   = rd_row_ff;
      head_in  = head_ff;
      fresh_in = fresh_ff;
      count_in = count_ff;
      o_status = sfla_pkg::STATUS_OK;
      o_slot   = slot_ff;
      o_fd     = rd_row_ff.fd;
      o_data   = rd_row_ff.data;
      o_mem    = rd_row_ff.mem;
      o_rel    = 1'b0;
      case (kind_ff)
         sfla_pkg::REQ_ALLOC: begin
            if (head_ff == sfla_pkg::CNT_W'(sfla_pkg::SLOTS)) begin
               o_status = sfla_pkg::STATUS_NO_FREE;
               o_slot   = '0;
               o_fd     = '0;
               o_data   = '0;
               o_mem    = '0;
            end else begin
               wr_en         = 1'b1;
               wr_row.in_use = 1'b1;
               wr_row.fd     = fd_ff;
               wr_row.data   = data_ff;
               wr_row.mem    = newmem_ff;
               if (head_fresh) begin
                  head_in  = head_ff + 1'b1;
                  fresh_in = head_ff + 1'b1;
               end else begin
                  head_in = rd_row_ff.next;
               end
               count_in = count_ff + 1'b1;
               o_slot   = sfla_pkg::ID_W'(head_ff);
               o_fd     = fd_ff;
               o_data   = data_ff;
               o_mem    = newmem_ff;
            end
         end
         sfla_pkg::REQ_FREE, sfla_pkg::REQ_MODIFY, sfla_pkg::REQ_LOOKUP: begin
            if (!live) begin
               o_status = sfla_pkg::STATUS_NOT_IN_USE;
               o_fd     = '0;
               o_data   = '0;
               o_mem    = '0;
            end else if (kind_ff == sfla_pkg::REQ_FREE) begin
               wr_en         = 1'b1;
               wr_row.in_use = 1'b0;
               wr_row.next   = head_ff;
               head_in       = sfla_pkg::CNT_W'(slot_ff);
               count_in      = count_ff - 1'b1;
               o_rel         = (rd_row_ff.mem != sfla_pkg::NONE_MEM);
            end else if (kind_ff == sfla_pkg::REQ_MODIFY) begin
               wr_en       = 1'b1;
               wr_row.data = data_ff;
               o_data      = data_ff;
            end
         end
         default: begin
            o_status = sfla_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         fresh_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= o_status;
         slot_out_ff <= o_slot;
         fd_out_ff   <= o_fd;
         data_out_ff <= o_data;
         mem_out_ff  <= o_mem;
         rel_ff      <= o_rel;
         live_ff     <= sfla_pkg::LIVE_W'(count_in);
      end
   end

   assign rsp_tdata = {2'b00, live_ff, rel_ff, mem_out_ff, data_out_ff, fd_out_ff, slot_out_ff};
   assign rsp_tuser = status_ff;

endmodule

// ===== rtl/slot_free_list_allocator_top.sv =====
`timescale 1ns / 1ps

// Slot allocator over a 1024-entry slot table with a linked free list: each
// item is an allocate, free, modify or lookup, and each gives exactly one
// result item with a status, the slot's contents and the live count. An item
// first reads the slot's row from the single-port slot table RAM, then updates
// the free list and writes the row back once the previous result is taken;
// the block takes a new item only after that write-back. The table needs no
// clearing pass after reset: a fill mark tracks which slots were ever handed
// out, and all others count as free and linked in order.
module slot_free_list_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot_id[9:0], fd[25:10], user_data[57:26], with_memory[58],
   // memory_index[73:59], zero fill[79:74]
   input  logic [79:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot_out[9:0], fd_out[25:10], data_out[57:26], mem_out[73:58],
   // release_memory[74], live_count[85:75], zero fill[87:86]
   output logic [87:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   sfla_pkg::cmd_type cmd;

   sfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sfla_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== rtl/sfla_chk.sv =====
`timescale 1ns / 1ps

module sfla_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in work");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[85:75] <= 11'(sfla_pkg::SLOTS))
      else $error("live count beyond slot count");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[74] |-> rsp_tuser == sfla_pkg::STATUS_OK)
      else $error("release flagged on a failed item");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item valid right after reset");

endmodule

bind slot_free_list_allocator_top sfla_chk u_sfla_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/tb_slot_free_list_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_slot_free_list_allocator_top;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PERCENT = 36;

   typedef struct packed {
      sfla_pkg::status_type        status;
      logic [sfla_pkg::ID_W-1:0]   slot;
      logic [sfla_pkg::FD_W-1:0]   fd;
      logic [sfla_pkg::DATA_W-1:0] word;
      logic [sfla_pkg::MEM_W-1:0]  mem;
      logic                        release_mem;
      logic [sfla_pkg::LIVE_W-1:0] live;
   } slot_result_type;

   typedef struct {
      sfla_pkg::req_kind_type      kind;
      logic [sfla_pkg::ID_W-1:0]   slot;
      logic [sfla_pkg::FD_W-1:0]   fd;
      logic [sfla_pkg::DATA_W-1:0] word;
      logic                        with_mem;
      logic [sfla_pkg::MIDX_W-1:0] bind_idx;
      bit                          fixed;
      slot_result_type             result;
   } stim_row_type;

   typedef struct {
      bit              fixed;
      slot_result_type result;
   } fixed_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   slot_free_list_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the slot table and its free list.
   logic [sfla_pkg::CNT_W-1:0]  model_head;
   logic [sfla_pkg::CNT_W-1:0]  model_link [sfla_pkg::SLOTS];
   bit                          model_used [sfla_pkg::SLOTS];
   logic [sfla_pkg::FD_W-1:0]   model_fd   [sfla_pkg::SLOTS];
   logic [sfla_pkg::DATA_W-1:0] model_data [sfla_pkg::SLOTS];
   logic [sfla_pkg::MEM_W-1:0]  model_mem  [sfla_pkg::SLOTS];
   logic [sfla_pkg::LIVE_W-1:0] model_live;

   slot_result_type  expected_slot_results [$];
   fixed_result_type typed_results [$];
   stim_row_type     directed_rows [$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  items_accepted = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 1'b0;
   bit  hold_results = 1'b0;

   initial begin
      for (int i = 0; i < sfla_pkg::SLOTS; i++) begin
         model_link[i] = sfla_pkg::CNT_W'(i + 1);
         model_used[i] = 1'b0;
         model_fd[i]   = '0;
         model_data[i] = '0;
         model_mem[i]  = '0;
      end
      model_head = '0;
      model_live = '0;
   end

   function automatic slot_result_type predict_slot_op(
         sfla_pkg::req_kind_type kind,
         logic [sfla_pkg::ID_W-1:0] slot,
         logic [sfla_pkg::FD_W-1:0] fd,
         logic [sfla_pkg::DATA_W-1:0] word,
         logic with_mem,
         logic [sfla_pkg::MIDX_W-1:0] bind_idx);
      slot_result_type r;
      logic [sfla_pkg::ID_W-1:0] h;
      r = '0;
      if (kind == sfla_pkg::REQ_ALLOC) begin
         if (model_head >= sfla_pkg::SLOTS) begin
            r.status = sfla_pkg::STATUS_NO_FREE;
         end else begin
            h = model_head[sfla_pkg::ID_W-1:0];
            model_fd[h]   = fd;
            model_data[h] = word;
            model_mem[h]  = with_mem ? {1'b0, bind_idx} : sfla_pkg::NONE_MEM;
            model_used[h] = 1'b1;
            model_head    = model_link[h];
            model_live    = model_live + 1'b1;
            r.status = sfla_pkg::STATUS_OK;
            r.slot   = h;
            r.fd     = fd;
            r.word   = word;
            r.mem    = model_mem[h];
         end
      end else if (!model_used[slot]) begin
         r.status = sfla_pkg::STATUS_NOT_IN_USE;
         r.slot   = slot;
      end else begin
         r.status = sfla_pkg::STATUS_OK;
         r.slot   = slot;
         if (kind == sfla_pkg::REQ_FREE) begin
            r.release_mem    = (model_mem[slot] != sfla_pkg::NONE_MEM);
            model_used[slot] = 1'b0;
            model_link[slot] = model_head;
            model_head       = {1'b0, slot};
            model_live       = model_live - 1'b1;
         end else if (kind == sfla_pkg::REQ_MODIFY) begin
            model_data[slot] = word;
         end
         r.fd   = model_fd[slot];
         r.word = model_data[slot];
         r.mem  = model_mem[slot];
      end
      r.live = model_live;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      slot_result_type  want;
      slot_result_type  got;
      fixed_result_type typed;
      if (!reset && req_tvalid && req_tready) begin
         want = predict_slot_op(sfla_pkg::req_kind_type'(req_tuser), req_tdata[9:0],
                                req_tdata[25:10], req_tdata[57:26], req_tdata[58],
                                req_tdata[73:59]);
         typed = typed_results.pop_front();
         expected_slot_results.push_back(typed.fixed ? typed.result : want);
         items_accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_slot_results.size() == 0) begin
            $error("result arrived with no expectation waiting");
            mismatches++;
         end else begin
            want = expected_slot_results.pop_front();
            got.status      = sfla_pkg::status_type'(rsp_tuser);
            got.slot        = rsp_tdata[9:0];
            got.fd          = rsp_tdata[25:10];
            got.word        = rsp_tdata[57:26];
            got.mem         = rsp_tdata[73:58];
            got.release_mem = rsp_tdata[74];
            got.live        = rsp_tdata[85:75];
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("slot_out", 32'(want.slot), 32'(got.slot));
            compare_field("fd_out", 32'(want.fd), 32'(got.fd));
            compare_field("data_out", want.word, got.word);
            compare_field("mem_out", 32'(want.mem), 32'(got.mem));
            compare_field("release_memory", 32'(want.release_mem), 32'(got.release_mem));
            compare_field("live_count", 32'(want.live), 32'(got.live));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic send_item(stim_row_type row);
      fixed_result_type typed;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      typed.fixed  = row.fixed;
      typed.result = row.result;
      typed_results.push_back(typed);
      items_sent++;
      req_tvalid <= 1'b1;
      req_tuser  <= row.kind;
      req_tdata  <= {6'b0, row.bind_idx, row.with_mem, row.word, row.fd, row.slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_seen != items_accepted || items_accepted != items_sent)
         @(posedge clock);
   endtask

   function automatic logic [sfla_pkg::ID_W-1:0] pick_live_slot();
      int start;
      start = $urandom_range(0, sfla_pkg::SLOTS - 1);
      for (int i = 0; i < sfla_pkg::SLOTS; i++) begin
         if (model_used[(start + i) % sfla_pkg::SLOTS])
            return sfla_pkg::ID_W'((start + i) % sfla_pkg::SLOTS);
      end
      return sfla_pkg::ID_W'(start);
   endfunction

   function automatic stim_row_type random_row(sfla_pkg::req_kind_type kind);
      stim_row_type row;
      row.kind      = kind;
      row.slot      = ($urandom_range(0, 99) < 85) ? pick_live_slot()
                      : sfla_pkg::ID_W'($urandom_range(0, sfla_pkg::SLOTS - 1));
      row.fd        = sfla_pkg::FD_W'($urandom_range(0, 65535));
      row.word      = $urandom;
      row.with_mem  = 1'($urandom_range(0, 1));
      row.bind_idx  = sfla_pkg::MIDX_W'($urandom_range(0, 32767));
      row.fixed     = 1'b0;
      row.result    = '0;
      return row;
   endfunction

   function automatic sfla_pkg::req_kind_type random_kind();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return sfla_pkg::REQ_ALLOC;
      if (pick < 65) return sfla_pkg::REQ_FREE;
      if (pick < 82) return sfla_pkg::REQ_MODIFY;
      return sfla_pkg::REQ_LOOKUP;
   endfunction

   function automatic stim_row_type pred_row(sfla_pkg::req_kind_type kind,
                                             logic [sfla_pkg::ID_W-1:0] slot,
                                             logic [sfla_pkg::FD_W-1:0] fd,
                                             logic [sfla_pkg::DATA_W-1:0] word,
                                             logic with_mem,
                                             logic [sfla_pkg::MIDX_W-1:0] bind_idx);
      stim_row_type row;
      row.kind      = kind;
      row.slot      = slot;
      row.fd        = fd;
      row.word      = word;
      row.with_mem  = with_mem;
      row.bind_idx  = bind_idx;
      row.fixed     = 1'b0;
      row.result    = '0;
      return row;
   endfunction

   function automatic stim_row_type fixed_row(sfla_pkg::req_kind_type kind,
                                              logic [sfla_pkg::ID_W-1:0] slot,
                                              logic [sfla_pkg::FD_W-1:0] fd,
                                              logic [sfla_pkg::DATA_W-1:0] word,
                                              logic with_mem,
                                              logic [sfla_pkg::MIDX_W-1:0] bind_idx,
                                              sfla_pkg::status_type status,
                                              logic [sfla_pkg::ID_W-1:0] slot_o,
                                              logic [sfla_pkg::MEM_W-1:0] mem_o,
                                              logic [sfla_pkg::LIVE_W-1:0] live);
      stim_row_type row;
      row = pred_row(kind, slot, fd, word, with_mem, bind_idx);
      row.fixed         = 1'b1;
      row.result        = '0;
      row.result.status = status;
      row.result.slot   = slot_o;
      row.result.live   = live;
      if (status == sfla_pkg::STATUS_OK) begin
         row.result.fd   = fd;
         row.result.word = word;
         row.result.mem  = mem_o;
      end
      return row;
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_item(random_row(random_kind()));
   endtask

   initial begin
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_LOOKUP, 10'd0, 16'h1111, 32'h1, 1'b1,
                                        15'h1, sfla_pkg::STATUS_NOT_IN_USE, 10'd0, '0,
                                        11'd0));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_FREE, 10'd1023, 16'h0, 32'h0, 1'b0,
                                        15'h0, sfla_pkg::STATUS_NOT_IN_USE, 10'd1023, '0,
                                        11'd0));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_MODIFY, 10'd512, 16'hFFFF,
                                        32'hFFFFFFFF, 1'b1, 15'h7FFF,
                                        sfla_pkg::STATUS_NOT_IN_USE, 10'd512, '0, 11'd0));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_ALLOC, 10'h3FF, 16'hFFFF,
                                        32'h7FFFFFFF, 1'b1, 15'h7FFF, sfla_pkg::STATUS_OK,
                                        10'd0, 16'h7FFF, 11'd1));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_ALLOC, 10'd0, 16'h0, 32'h80000000,
                                        1'b0, 15'h7FFF, sfla_pkg::STATUS_OK, 10'd1,
                                        sfla_pkg::NONE_MEM, 11'd2));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_ALLOC, 10'd0, 16'h1234, 32'h0, 1'b1,
                                        15'h0, sfla_pkg::STATUS_OK, 10'd2, 16'h0, 11'd3));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_LOOKUP, 10'd1, 16'h0, 32'h0, 1'b0,
                                       15'h0));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_MODIFY, 10'd1, 16'h0, 32'hFFFFFFFF,
                                       1'b1, 15'h5));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_FREE, 10'd0, 16'h0, 32'h0, 1'b0,
                                       15'h0));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_FREE, 10'd0, 16'h0, 32'h0, 1'b0,
                                        15'h0, sfla_pkg::STATUS_NOT_IN_USE, 10'd0, '0,
                                        11'd2));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_ALLOC, 10'd0, 16'h00FF, 32'h55AA55AA,
                                       1'b1, 15'h2AAA));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_FREE, 10'd1, 16'h0, 32'h0, 1'b0,
                                       15'h0));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_FREE, 10'd2, 16'h0, 32'h0, 1'b0,
                                       15'h0));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_LOOKUP, 10'd2, 16'h0, 32'h0, 1'b0,
                                        15'h0, sfla_pkg::STATUS_NOT_IN_USE, 10'd2, '0,
                                        11'd1));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_ALLOC, 10'd0, 16'hFF00, 32'hAA55AA55,
                                       1'b1, 15'h5555));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_ALLOC, 10'd0, 16'h8001, 32'h00000001,
                                       1'b0, 15'h1));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_ALLOC, 10'd0, 16'h7FFE, 32'hFFFFFFFE,
                                       1'b1, 15'h4000));
      directed_rows.push_back(fixed_row(sfla_pkg::REQ_LOOKUP, 10'd1023, 16'h0, 32'h0, 1'b0,
                                        15'h0, sfla_pkg::STATUS_NOT_IN_USE, 10'd1023, '0,
                                        11'd4));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_MODIFY, 10'd0, 16'h0, 32'h12345678,
                                       1'b0, 15'h0));
      directed_rows.push_back(pred_row(sfla_pkg::REQ_LOOKUP, 10'd3, 16'h0, 32'h0, 1'b0,
                                       15'h0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      wait_all_results();

      run_random(250);
      hold_results = 1'b1;
      run_random(60);
      no_idle = 1'b1;
      run_random(200);
      no_idle = 1'b0;
      run_random(220);
      wait_all_results();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_slot_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sfla_pkg.sv
rtl/sfla_ctrl.sv
rtl/sfla_dp.sv
rtl/slot_free_list_allocator_top.sv
rtl/sfla_chk.sv
verif/tb_slot_free_list_allocator_top.sv
